// ----- design/assert_macros.svh -----
// Concurrent assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define FHPA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define FHPA_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define FHPA_ASSERT(lbl, clk, rst_n, prop, msg)

`define FHPA_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ----- design/fhpa_pkg.sv -----
`timescale 1ns / 1ps

package fhpa_pkg;

    localparam int HANDLE_W      = 6;
    localparam int HANDLE_SPACE  = 1 << HANDLE_W;
    localparam int POOL_SIZE_DEF = 64;

    typedef enum logic [1:0] {
        CMD_ALLOC     = 2'd0,
        CMD_TRY_ALLOC = 2'd1,
        CMD_DEALLOC   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NONE_FREE = 2'd1,
        ST_NOT_HELD  = 2'd2,
        ST_EXHAUSTED = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [HANDLE_W-1:0] handle_in;
    } req_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle_out;
        logic [1:0]          status;
    } resp_t;

    typedef struct packed {
        logic                push;
        logic                pop;
        logic [HANDLE_W-1:0] push_data;
    } fifo_ctl_t;

    typedef struct packed {
        logic                empty;
        logic [HANDLE_W:0]   count;
        logic [HANDLE_W-1:0] head_data;
    } fifo_stat_t;

endpackage

// ----- design/fhpa_free_fifo.sv -----
`timescale 1ns / 1ps

module fhpa_free_fifo #(
    parameter int DEPTH = fhpa_pkg::POOL_SIZE_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fhpa_pkg::fifo_ctl_t    ctl,
    output fhpa_pkg::fifo_stat_t   stat
);
    import fhpa_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    logic [HANDLE_W-1:0] mem [DEPTH];

    logic [PTR_W-1:0]    head_reg;
    logic [PTR_W-1:0]    head_next;
    logic [PTR_W-1:0]    tail_reg;
    logic [PTR_W-1:0]    tail_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [HANDLE_W-1:0] rd_q_reg;
    logic                byp_reg;
    logic [HANDLE_W-1:0] byp_data_reg;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctl.pop)
        begin
            head_next  = (head_reg == LAST_PTR) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        if (ctl.push)
        begin
            tail_next  = (tail_reg == LAST_PTR) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // prefetch the next head entry; forward a write landing on the same entry
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[tail_reg] <= ctl.push_data;
        end
        rd_q_reg     <= mem[head_next];
        byp_reg      <= ctl.push && (tail_reg == head_next);
        byp_data_reg <= ctl.push_data;
    end

    assign stat.empty     = (count_reg == '0);
    assign stat.count     = (HANDLE_W + 1)'(count_reg);
    assign stat.head_data = byp_reg ? byp_data_reg : rd_q_reg;

endmodule

// ----- design/fifo_handle_pool_allocator_core.sv -----
`timescale 1ns / 1ps
// Requests register in in_reg; results then in result_reg, with the strobe in done_reg.
// Throughput: one request per cycle; busy is never raised.
// The free-queue head is prefetched from a registered-read memory, so pops run back to back.
// Reset clears queue pointers and count, minted count, held map, input valid and the strobe.
// Queue storage is not cleared. Results show for one cycle only; the receiver cannot stall.
`include "assert_macros.svh"

module fifo_handle_pool_allocator_core #(
    parameter int POOL_SIZE = fhpa_pkg::POOL_SIZE_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  fhpa_pkg::req_t  req,
    output logic            done,
    output fhpa_pkg::resp_t result
);
    import fhpa_pkg::*;

    localparam int CAPACITY = (POOL_SIZE < HANDLE_SPACE) ? POOL_SIZE : HANDLE_SPACE;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0]  CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [HANDLE_W:0] CAP_H   = (HANDLE_W + 1)'(CAPACITY);

    logic                in_valid_reg;
    req_t                in_reg;
    logic [CAPACITY-1:0] held_reg;
    logic [CAPACITY-1:0] held_next;
    logic [CNT_W-1:0]    minted_reg;
    logic [CNT_W-1:0]    minted_next;
    logic                done_reg;
    resp_t               result_reg;
    resp_t               resp_next;
    fifo_ctl_t           fctl;
    fifo_stat_t          fstat;

    fhpa_free_fifo #(
        .DEPTH (CAPACITY)
    ) u_free_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (fctl),
        .stat  (fstat)
    );

    always_comb
    begin
        resp_next   = '{handle_out: '0, status: ST_OK};
        fctl        = '{push: 1'b0, pop: 1'b0, push_data: in_reg.handle_in};
        held_next   = held_reg;
        minted_next = minted_reg;
        if (in_valid_reg)
        begin
            unique case (in_reg.cmd)
                CMD_ALLOC, CMD_TRY_ALLOC:
                begin
                    priority if (!fstat.empty)
                    begin
                        fctl.pop             = 1'b1;
                        resp_next.handle_out = fstat.head_data;
                        held_next[fstat.head_data[IDX_W-1:0]] = 1'b1;
                    end
                    else if (in_reg.cmd == CMD_TRY_ALLOC)
                    begin
                        resp_next.status = ST_NONE_FREE;
                    end
                    else if (minted_reg < CAP_CNT)
                    begin
                        resp_next.handle_out = HANDLE_W'(minted_reg);
                        minted_next          = minted_reg + 1'b1;
                        held_next[minted_reg[IDX_W-1:0]] = 1'b1;
                    end
                    else
                    begin
                        resp_next.status = ST_EXHAUSTED;
                    end
                end
                CMD_DEALLOC:
                begin
                    if (({1'b0, in_reg.handle_in} < CAP_H)
                        && held_reg[in_reg.handle_in[IDX_W-1:0]])
                    begin
                        fctl.push = 1'b1;
                        held_next[in_reg.handle_in[IDX_W-1:0]] = 1'b0;
                    end
                    else
                    begin
                        resp_next.status = ST_NOT_HELD;
                    end
                end
                default:
                begin
                    resp_next.status = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            held_reg     <= '0;
            minted_reg   <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
            held_reg     <= held_next;
            minted_reg   <= minted_next;
            done_reg     <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            in_reg <= req;
        end
        result_reg <= resp_next;
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    `FHPA_ASSERT(a_strobe_follows_beat, clk, rst_n, (start && !busy) |-> ##2 done, "missing result strobe")
    `FHPA_ASSERT(a_no_stray_strobe, clk, rst_n, done |-> $past(start && !busy, 2), "result without a request")
    `FHPA_ASSERT(a_exhausted_state, clk, rst_n, (done && result.status == ST_EXHAUSTED) |-> (fstat.empty && minted_reg == CAP_CNT), "exhaustion reported with handles left")
    `FHPA_ASSERT(a_handle_balance, clk, rst_n, ($countones(held_reg) + int'(fstat.count)) == int'(minted_reg), "held plus free does not match minted")

endmodule

// ----- verif/pool_checker.sv -----
`timescale 1ns / 1ps

module pool_checker #(
    parameter int POOL_SIZE = fhpa_pkg::POOL_SIZE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  fhpa_pkg::req_t                    req,
    input  logic                              done,
    input  fhpa_pkg::resp_t                   result,
    output logic [fhpa_pkg::HANDLE_SPACE-1:0] held_hint,
    output int                                errors,
    output int                                outstanding,
    output int                                checked,
    output int                                none_free_seen,
    output int                                not_held_seen,
    output int                                exhausted_seen
);
    import fhpa_pkg::*;

    localparam int CAPACITY = (POOL_SIZE < HANDLE_SPACE) ? POOL_SIZE : HANDLE_SPACE;

    logic [HANDLE_W-1:0]     free_store [HANDLE_SPACE];
    logic [HANDLE_W-1:0]     free_rd;
    logic [HANDLE_W-1:0]     free_wr;
    logic [HANDLE_W:0]       free_cnt;
    logic [HANDLE_SPACE-1:0] held_map;
    logic [HANDLE_W:0]       minted;
    resp_t                   awaited_resp [$];
    int                      err_n;
    int                      chk_n;
    int                      nf_n;
    int                      nh_n;
    int                      ex_n;

    function automatic resp_t grant_or_release(req_t r);
        resp_t o;
        o.handle_out = '0;
        o.status     = ST_OK;
        if (r.cmd == CMD_ALLOC || r.cmd == CMD_TRY_ALLOC)
        begin
            if (free_cnt != 0)
            begin
                o.handle_out = free_store[free_rd];
                free_rd      = free_rd + 1'b1;
                free_cnt     = free_cnt - 1'b1;
                held_map[o.handle_out] = 1'b1;
            end
            else if (r.cmd == CMD_TRY_ALLOC)
            begin
                o.status = ST_NONE_FREE;
            end
            else if (int'(minted) < CAPACITY)
            begin
                o.handle_out = minted[HANDLE_W-1:0];
                minted       = minted + 1'b1;
                held_map[o.handle_out] = 1'b1;
            end
            else
            begin
                o.status = ST_EXHAUSTED;
            end
        end
        else if (r.cmd == CMD_DEALLOC)
        begin
            if (int'(r.handle_in) < CAPACITY && held_map[r.handle_in]
                && int'(free_cnt) < HANDLE_SPACE)
            begin
                held_map[r.handle_in] = 1'b0;
                free_store[free_wr]   = r.handle_in;
                free_wr               = free_wr + 1'b1;
                free_cnt              = free_cnt + 1'b1;
            end
            else
            begin
                o.status = ST_NOT_HELD;
            end
        end
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        resp_t want;
        if (!rst_n)
        begin
            free_rd  = '0;
            free_wr  = '0;
            free_cnt = '0;
            held_map = '0;
            minted   = '0;
            awaited_resp.delete();
        end
        else
        begin
            if (start && !busy)
                awaited_resp.push_back(grant_or_release(req));
            if (done)
            begin
                if (awaited_resp.size() == 0)
                begin
                    $display("%0t: result with nothing outstanding, got handle %0d status %0d",
                             $time, result.handle_out, result.status);
                    err_n++;
                end
                else
                begin
                    want = awaited_resp.pop_front();
                    chk_n++;
                    if (result.handle_out !== want.handle_out)
                    begin
                        $display("%0t: handle_out mismatch, expected %0d, actual %0d",
                                 $time, want.handle_out, result.handle_out);
                        err_n++;
                    end
                    if (result.status !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, result.status);
                        err_n++;
                    end
                    case (want.status)
                        ST_NONE_FREE: nf_n++;
                        ST_NOT_HELD:  nh_n++;
                        ST_EXHAUSTED: ex_n++;
                        default: ;
                    endcase
                end
            end
        end
        held_hint      <= held_map;
        errors         <= err_n;
        outstanding    <= awaited_resp.size();
        checked        <= chk_n;
        none_free_seen <= nf_n;
        not_held_seen  <= nh_n;
        exhausted_seen <= ex_n;
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import fhpa_pkg::*;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         RANDOM_BEATS = 1050;
    localparam int         SEG_LEN      = 80;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         DRAIN_CYCLES = 8;

    logic                    clk   = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    req_t                    req   = '0;
    logic                    busy;
    logic                    done;
    resp_t                   result;
    logic [HANDLE_SPACE-1:0] held_hint;
    int                      errors;
    int                      outstanding;
    int                      checked;
    int                      none_free_seen;
    int                      not_held_seen;
    int                      exhausted_seen;
    int                      cycles     = 0;
    int                      beats_sent = 0;
    int                      idle_pct   = 34;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still outstanding",
                     cycles, outstanding);
            $display("*** FAILED ***");
            $finish;
        end
    end

    fifo_handle_pool_allocator_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .done   (done),
        .result (result)
    );

    pool_checker pool_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req            (req),
        .done           (done),
        .result         (result),
        .held_hint      (held_hint),
        .errors         (errors),
        .outstanding    (outstanding),
        .checked        (checked),
        .none_free_seen (none_free_seen),
        .not_held_seen  (not_held_seen),
        .exhausted_seen (exhausted_seen)
    );

    task automatic pause_sender();
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            req   <= req_t'($urandom);
            @(posedge clk);
        end
    endtask

    task automatic send_beat(input logic [1:0] c, input logic [HANDLE_W-1:0] h);
        pause_sender();
        start <= 1'b1;
        req   <= req_t'({c, h});
        do
            @(posedge clk);
        while (busy);
        beats_sent++;
    endtask

    function automatic logic [HANDLE_W-1:0] pick_held();
        logic [HANDLE_W-1:0] pick;
        int                  base;
        bit                  found;
        base  = $urandom_range(HANDLE_SPACE - 1);
        pick  = HANDLE_W'($urandom);
        found = 1'b0;
        for (int i = 0; i < HANDLE_SPACE; i++)
        begin
            if (!found && held_hint[(base + i) % HANDLE_SPACE])
            begin
                pick  = HANDLE_W'((base + i) % HANDLE_SPACE);
                found = 1'b1;
            end
        end
        return pick;
    endfunction

    initial
    begin
        int                  n;
        int                  seg;
        int                  alloc_w;
        logic [1:0]          c;
        logic [HANDLE_W-1:0] h;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(CMD_TRY_ALLOC, 6'd0);
        send_beat(CMD_DEALLOC, 6'd0);
        send_beat(CMD_DEALLOC, 6'd63);
        send_beat(CMD_UNUSED, 6'd63);
        send_beat(CMD_ALLOC, 6'd63);
        send_beat(CMD_ALLOC, 6'd0);
        send_beat(CMD_ALLOC, 6'd21);
        send_beat(CMD_DEALLOC, 6'd1);
        send_beat(CMD_DEALLOC, 6'd1);
        send_beat(CMD_DEALLOC, 6'd2);
        send_beat(CMD_TRY_ALLOC, 6'd42);
        send_beat(CMD_ALLOC, 6'd0);
        send_beat(CMD_ALLOC, 6'd0);
        send_beat(CMD_TRY_ALLOC, 6'd63);
        send_beat(CMD_DEALLOC, 6'd0);
        send_beat(CMD_DEALLOC, 6'd3);
        send_beat(CMD_UNUSED, 6'd0);
        send_beat(CMD_ALLOC, 6'd0);
        send_beat(CMD_ALLOC, 6'd0);
        send_beat(CMD_DEALLOC, 6'd40);

        n       = 0;
        seg     = -1;
        alloc_w = 50;
        while (n < RANDOM_BEATS)
        begin
            idle_pct = (n < RANDOM_BEATS / 3) ? 34 : ((n < 2 * RANDOM_BEATS / 3) ? 68 : 0);
            if (n / SEG_LEN != seg)
            begin
                seg = n / SEG_LEN;
                case (seg % 4)
                    1:       alloc_w = 95;
                    3:       alloc_w = 8;
                    default: alloc_w = $urandom_range(75, 25);
                endcase
            end
            h = HANDLE_W'($urandom);
            if ($urandom_range(99) < 4)
            begin
                send_beat(CMD_UNUSED, h);
            end
            else
            begin
                if ($urandom_range(99) < alloc_w)
                begin
                    c = ($urandom_range(3) == 0) ? CMD_TRY_ALLOC : CMD_ALLOC;
                end
                else
                begin
                    c = CMD_DEALLOC;
                    if ($urandom_range(99) < 85)
                        h = pick_held();
                end
                send_beat(c, h);
                n++;
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run: %0d requests sent, %0d results checked, %0d mismatches",
                 beats_sent, checked, errors);
        $display("Refusals seen: none free %0d, not held %0d, capacity exhausted %0d",
                 none_free_seen, not_held_seen, exhausted_seen);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
